// ===== hw/rtl/rri_pkg.sv =====
// ----------------------------------------------------------------------------
// rri_pkg
// Shared types and constants of the RTCP report interval pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package rri_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam int unsigned CNT_W   = 16;  // member / sender / size fields
  localparam int unsigned SHARE_W = 17;  // Q0.16 share, one included
  localparam int unsigned BPS_W   = 32;  // bandwidth and minimum registers
  localparam int unsigned BWQ_W   = 48;  // bandwidth in Q.16
  localparam int unsigned SN_W    = 32;  // size times count
  localparam int unsigned NS_W    = 30;  // width of one second in ns
  localparam int unsigned X_W     = 62;  // size * count * 1e9
  localparam int unsigned MIN_W   = 42;  // minimum interval in ns
  localparam int unsigned IV_W    = 63;  // result width

  localparam logic [SHARE_W-1:0] SHARE_ONE       = 17'd65536;
  localparam logic [CNT_W-1:0]   BYE_MIN_MEMBERS = 16'd50;
  localparam logic [NS_W-1:0]    NS_PER_SEC      = 30'd1000000000;
  localparam logic [9:0]         NS_PER_US       = 10'd1000;
  localparam logic [9:0]         NS_PER_US_HALF  = 10'd500;
  localparam logic [BPS_W-1:0]   MIN_US_RST      = 32'd5000000;
  localparam logic [SHARE_W-1:0] SHARE_RST       = 17'd16384;

  typedef enum logic [1:0] {
    REG_RTCP_BPS     = 2'd0,
    REG_SENDER_SHARE = 2'd1,
    REG_MIN_INTERVAL = 2'd2
  } rri_reg_t;

  typedef struct packed {
    logic no_rtcp;   // effective bandwidth too small
    logic bye_zero;  // small BYE session, result is zero
  } rri_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rri_prep.sv =====
// ----------------------------------------------------------------------------
// rri_prep
// Three front stages: bandwidth split, products, fixed-point divisor and
// the no-bandwidth test.
// ----------------------------------------------------------------------------
`default_nettype none
module rri_prep import rri_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int unsigned BWW = 32 + FRACTION_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_vld,
  input  wire logic               req_type,
  input  wire logic [CNT_W-1:0]   member_count,
  input  wire logic [CNT_W-1:0]   sender_count,
  input  wire logic [CNT_W-1:0]   leaving_count,
  input  wire logic [CNT_W-1:0]   avg_packet_bytes,
  input  wire logic               local_sends,
  input  wire logic               first_report,
  input  wire logic [BPS_W-1:0]   bps,
  input  wire logic [SHARE_W-1:0] share,
  input  wire logic [BPS_W-1:0]   min_us,
  output logic                    vld_o,
  output logic [X_W-1:0]          x_o,
  output logic [BWW-1:0]          dsr_o,
  output logic [MIN_W-1:0]        min_o,
  output rri_ctl_t                ctl_o
);

  localparam int unsigned FXW = BWQ_W + FRACTION_BITS;
  localparam logic [BWW-1:0] THR_RPT = BWW'((64'd1 << FRACTION_BITS) / 64'd100000);
  localparam logic [BWW-1:0] THR_BYE = BWW'((64'd1 << FRACTION_BITS) / 64'd10000);

  // stage 1
  logic [SHARE_W-1:0] s_sat, r_sh;
  logic [32:0]        sen_lhs, sen_rhs;
  logic               split;
  logic [SHARE_W-1:0] sh1_nxt;
  logic [CNT_W-1:0]   n1_nxt;
  logic               v1_r, half1_r, bye1_r, zero1_r;
  logic [SHARE_W-1:0] sh1_r;
  logic [CNT_W-1:0]   n1_r, size1_r;

  assign s_sat   = (share > SHARE_ONE) ? SHARE_ONE : share;
  assign r_sh    = SHARE_ONE - s_sat;
  assign sen_lhs = {1'b0, sender_count, 16'd0};
  assign sen_rhs = 33'(member_count) * 33'(s_sat);
  assign split   = sen_lhs <= sen_rhs;

  always_comb begin
    sh1_nxt = SHARE_ONE;
    n1_nxt  = member_count;
    if (req_type) begin
      sh1_nxt = r_sh;
      n1_nxt  = leaving_count;
    end else if (split) begin
      if (local_sends) begin
        sh1_nxt = s_sat;
        n1_nxt  = sender_count;
      end else begin
        sh1_nxt = r_sh;
        n1_nxt  = member_count - sender_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh1_r   <= sh1_nxt;
      n1_r    <= n1_nxt;
      size1_r <= avg_packet_bytes;
      half1_r <= req_type | first_report;
      bye1_r  <= req_type;
      zero1_r <= req_type && (member_count < BYE_MIN_MEMBERS);
    end
  end

  // stage 2
  logic               v2_r, bye2_r, zero2_r;
  logic [BWQ_W-1:0]   bw2_r;
  logic [SN_W-1:0]    sn2_r;
  logic [MIN_W-1:0]   min2_r;
  logic [48:0]        bw_prod;

  assign bw_prod = 49'(bps) * 49'(sh1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bw2_r   <= bw_prod[BWQ_W-1:0];
      sn2_r   <= SN_W'(size1_r) * SN_W'(n1_r);
      min2_r  <= MIN_W'(min_us) * MIN_W'(half1_r ? NS_PER_US_HALF : NS_PER_US);
      bye2_r  <= bye1_r;
      zero2_r <= zero1_r;
    end
  end

  // stage 3
  logic [FXW-1:0] bw_wide;
  logic [BWW-1:0] bw_fx;
  logic           v3_r;

  assign bw_wide = (FXW'(bw2_r) << FRACTION_BITS) >> 16;
  assign bw_fx   = bw_wide[BWW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o           <= X_W'(sn2_r) * X_W'(NS_PER_SEC);
      dsr_o         <= bw_fx;
      min_o         <= min2_r;
      ctl_o.no_rtcp <= bw_fx <= (bye2_r ? THR_BYE : THR_RPT);
      ctl_o.bye_zero <= zero2_r;
    end
  end

  assign vld_o = v3_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rri_div_step.sv =====
// ----------------------------------------------------------------------------
// rri_div_step
// One registered restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module rri_div_step import rri_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int unsigned BWW = 32 + FRACTION_BITS,
  localparam int unsigned DW  = X_W + FRACTION_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             vld_i,
  input  wire rri_ctl_t         ctl_i,
  input  wire logic [BWW-1:0]   rem_i,
  input  wire logic [DW-1:0]    dvd_i,
  input  wire logic [IV_W-1:0]  quo_i,
  input  wire logic             over_i,
  input  wire logic [BWW-1:0]   dsr_i,
  input  wire logic [MIN_W-1:0] min_i,
  output logic                  vld_o,
  output rri_ctl_t              ctl_o,
  output logic [BWW-1:0]        rem_o,
  output logic [DW-1:0]         dvd_o,
  output logic [IV_W-1:0]       quo_o,
  output logic                  over_o,
  output logic [BWW-1:0]        dsr_o,
  output logic [MIN_W-1:0]      min_o
);

  logic [BWW:0]   trial, diff;
  logic           ge;

  assign trial = {rem_i, dvd_i[DW-1]};
  assign ge    = trial >= {1'b0, dsr_i};
  assign diff  = trial - {1'b0, dsr_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_o  <= ctl_i;
      rem_o  <= ge ? diff[BWW-1:0] : trial[BWW-1:0];
      dvd_o  <= {dvd_i[DW-2:0], 1'b0};
      quo_o  <= {quo_i[IV_W-2:0], ge};
      over_o <= over_i | quo_i[IV_W-1];  // a bit shifted out means saturation
      dsr_o  <= dsr_i;
      min_o  <= min_i;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rtcp_report_interval.sv =====
// ----------------------------------------------------------------------------
// rtcp_report_interval
// RTCP report / BYE interval in ns: split bandwidth, scale, pipelined
// division, clamp to the minimum and saturate to 63 bits.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Carries
// in_      input      in_valid / in_ready    one request item
// out_     output     out_valid / out_ready  interval_ns, no_rtcp
// cfg_     input      cfg_valid / cfg_ready  register index, write data
//
// One item enters per cycle while the output is not stalled; the divider
// resolves one quotient bit per stage.
// Synchronous active-low reset clears all valid bits and loads register
// defaults. A stalled output freezes the whole pipeline; in_ready is low
// while out_valid is high and out_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none
module rtcp_report_interval import rri_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_req_type,
  input  wire logic [CNT_W-1:0] in_member_count,
  input  wire logic [CNT_W-1:0] in_sender_count,
  input  wire logic [CNT_W-1:0] in_leaving_count,
  input  wire logic [CNT_W-1:0] in_avg_packet_bytes,
  input  wire logic             in_local_sends,
  input  wire logic             in_first_report,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [IV_W-1:0]       out_interval_ns,
  output logic                  out_no_rtcp,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [BPS_W-1:0] cfg_data
);

  localparam int unsigned BWW = 32 + FRACTION_BITS;
  localparam int unsigned DW  = X_W + FRACTION_BITS;

  logic en;
  logic [BPS_W-1:0]   bps_r, min_us_r;
  logic [SHARE_W-1:0] share_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r    <= '0;
      share_r  <= SHARE_RST;
      min_us_r <= MIN_US_RST;
    end else if (cfg_valid) begin
      case (rri_reg_t'(cfg_index))
        REG_RTCP_BPS:     bps_r    <= cfg_data;
        REG_SENDER_SHARE: share_r  <= cfg_data[SHARE_W-1:0];
        REG_MIN_INTERVAL: min_us_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic                v_s   [0:DW];
  rri_ctl_t            ctl_s [0:DW];
  logic [BWW-1:0]      rem_s [0:DW];
  logic [DW-1:0]       dvd_s [0:DW];
  logic [IV_W-1:0]     quo_s [0:DW];
  logic                ovr_s [0:DW];
  logic [BWW-1:0]      dsr_s [0:DW];
  logic [MIN_W-1:0]    min_s [0:DW];
  logic [X_W-1:0]      x_p;

  rri_prep #(.FRACTION_BITS(FRACTION_BITS)) u_prep (
    .clk, .rst_n, .en,
    .in_vld           (in_valid),
    .req_type         (in_req_type),
    .member_count     (in_member_count),
    .sender_count     (in_sender_count),
    .leaving_count    (in_leaving_count),
    .avg_packet_bytes (in_avg_packet_bytes),
    .local_sends      (in_local_sends),
    .first_report     (in_first_report),
    .bps              (bps_r),
    .share            (share_r),
    .min_us           (min_us_r),
    .vld_o            (v_s[0]),
    .x_o              (x_p),
    .dsr_o            (dsr_s[0]),
    .min_o            (min_s[0]),
    .ctl_o            (ctl_s[0])
  );

  assign rem_s[0] = '0;
  assign dvd_s[0] = {x_p, {FRACTION_BITS{1'b0}}};
  assign quo_s[0] = '0;
  assign ovr_s[0] = 1'b0;

  for (genvar g = 0; g < DW; g++) begin : g_div
    rri_div_step #(.FRACTION_BITS(FRACTION_BITS)) u_step (
      .clk, .rst_n, .en,
      .vld_i  (v_s[g]),   .ctl_i (ctl_s[g]),   .rem_i (rem_s[g]),
      .dvd_i  (dvd_s[g]), .quo_i (quo_s[g]),   .over_i(ovr_s[g]),
      .dsr_i  (dsr_s[g]), .min_i (min_s[g]),
      .vld_o  (v_s[g+1]), .ctl_o (ctl_s[g+1]), .rem_o (rem_s[g+1]),
      .dvd_o  (dvd_s[g+1]), .quo_o (quo_s[g+1]), .over_o(ovr_s[g+1]),
      .dsr_o  (dsr_s[g+1]), .min_o (min_s[g+1])
    );
  end

  // output register: saturate, clamp, apply special cases
  logic            out_valid_r, out_no_rtcp_r;
  logic [IV_W-1:0] out_iv_r, iv_sat, iv_nxt;

  always_comb begin
    iv_sat = ovr_s[DW] ? {IV_W{1'b1}} : quo_s[DW];
    iv_nxt = (iv_sat < IV_W'(min_s[DW])) ? IV_W'(min_s[DW]) : iv_sat;
    if (ctl_s[DW].bye_zero || ctl_s[DW].no_rtcp) begin
      iv_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_s[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_iv_r      <= iv_nxt;
      out_no_rtcp_r <= ctl_s[DW].no_rtcp && !ctl_s[DW].bye_zero;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_interval_ns = out_iv_r;
  assign out_no_rtcp     = out_no_rtcp_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rri_checker.sv =====
// ----------------------------------------------------------------------------
// rri_checker
// Port-level checks of the interval pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module rri_checker import rri_pkg::*; (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic [IV_W-1:0] out_interval_ns,
  input wire logic            out_no_rtcp
);

  a_no_rtcp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_rtcp |-> out_interval_ns == '0)
    else $error("no_rtcp item with nonzero interval");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_interval_ns))
    else $error("stalled item changed");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind rtcp_report_interval rri_checker u_rri_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_interval_ns (out_interval_ns),
  .out_no_rtcp     (out_no_rtcp)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rtcp_report_interval. Requests are driven with
// random gaps under several register settings. An interval calculator in the
// scoreboard predicts each result, and results are compared in order, field
// by field. The bench also holds off the receiver long enough to fill and
// stall the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import rri_pkg::*;

  localparam int LATENCY    = 3 + 62 + FRACTION_BITS_DEF + 1;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [62:0] SAT63 = {63{1'b1}};

  typedef struct {
    logic        bye;
    logic [15:0] members;
    logic [15:0] senders;
    logic [15:0] leaving;
    logic [15:0] size;
    logic        local_sends;
    logic        first;
  } request_t;

  typedef struct {
    logic [62:0] interval_ns;
    logic        no_rtcp;
  } interval_t;

  class interval_scoreboard;
    logic [31:0] bps;
    logic [16:0] share;
    logic [31:0] min_us;
    interval_t   pending[$];
    int          mismatches;

    function new();
      bps = 0;
      share = SHARE_RST;
      min_us = MIN_US_RST;
      mismatches = 0;
    endfunction

    function void set_reg(rri_reg_t idx, logic [31:0] data);
      case (idx)
        REG_RTCP_BPS:     bps = data;
        REG_SENDER_SHARE: share = data[16:0];
        REG_MIN_INTERVAL: min_us = data;
        default: ;
      endcase
    endfunction

    // Work out the wait time for one request under the current registers.
    function interval_t calc_interval(request_t rq);
      interval_t    res;
      logic [16:0]  s;
      logic [16:0]  r;
      logic [63:0]  bw;
      logic [63:0]  n;
      logic [63:0]  min_ns;
      logic [63:0]  thr;
      logic [63:0]  x;
      logic [127:0] q;
      s = (share > SHARE_ONE) ? SHARE_ONE : share;
      r = SHARE_ONE - s;
      res.interval_ns = '0;
      res.no_rtcp = 1'b0;
      if (rq.bye) begin
        if (rq.members < BYE_MIN_MEMBERS) return res;
        bw = 64'(bps) * 64'(r);
        n = 64'(rq.leaving);
        min_ns = 64'(min_us) * 64'd500;
        thr = (64'd1 << FRACTION_BITS_DEF) / 64'd10000;
      end else begin
        bw = 64'(bps) << 16;
        n = 64'(rq.members);
        min_ns = 64'(min_us) * (rq.first ? 64'd500 : 64'd1000);
        thr = (64'd1 << FRACTION_BITS_DEF) / 64'd100000;
        if (64'(rq.senders) * 64'(SHARE_ONE) <= 64'(rq.members) * 64'(s)) begin
          if (rq.local_sends) begin
            bw = 64'(bps) * 64'(s);
            n = 64'(rq.senders);
          end else begin
            bw = 64'(bps) * 64'(r);
            n = 64'(rq.members) - 64'(rq.senders);
          end
        end
      end
      bw = bw << (FRACTION_BITS_DEF - 16);
      if (bw <= thr) begin
        res.no_rtcp = 1'b1;
        return res;
      end
      x = 64'(rq.size) * n * 64'd1000000000;
      q = (128'(x) << FRACTION_BITS_DEF) / 128'(bw);
      if (q > 128'(SAT63)) q = 128'(SAT63);
      if (q < 128'(min_ns)) q = 128'(min_ns);
      res.interval_ns = q[62:0];
      return res;
    endfunction

    function void note_request(request_t rq);
      pending.push_back(calc_interval(rq));
    endfunction

    function void check_result(logic [62:0] iv, logic no);
      interval_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result interval=%0d no_rtcp=%0b", iv, no);
        return;
      end
      want = pending.pop_front();
      if (iv !== want.interval_ns || no !== want.no_rtcp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: interval exp %0d got %0d, no_rtcp exp %0b got %0b",
                   want.interval_ns, iv, want.no_rtcp, no);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic in_req_type, in_local_sends, in_first_report;
  logic [CNT_W-1:0] in_member_count, in_sender_count, in_leaving_count;
  logic [CNT_W-1:0] in_avg_packet_bytes;
  logic out_valid, out_ready;
  logic [IV_W-1:0] out_interval_ns;
  logic out_no_rtcp;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [BPS_W-1:0] cfg_data;

  interval_scoreboard sb;
  bit hold_req;
  bit no_idle;
  int quiet_cycles;

  rtcp_report_interval dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_req_type, .in_member_count, .in_sender_count,
    .in_leaving_count, .in_avg_packet_bytes, .in_local_sends, .in_first_report,
    .out_valid, .out_ready, .out_interval_ns, .out_no_rtcp,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic write_reg(rri_reg_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drive one item; valid stays up into the next item unless idle cycles are drawn.
  task automatic send_request(request_t rq);
    in_valid <= 1'b1;
    in_req_type <= rq.bye;
    in_member_count <= rq.members;
    in_sender_count <= rq.senders;
    in_leaving_count <= rq.leaving;
    in_avg_packet_bytes <= rq.size;
    in_local_sends <= rq.local_sends;
    in_first_report <= rq.first;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rq);
    while (!no_idle && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic request_t make_req(logic bye, int m, int s, int l, int z,
                                        logic ls, logic fr);
    request_t rq;
    rq.bye = bye;
    rq.members = 16'(m);
    rq.senders = 16'(s);
    rq.leaving = 16'(l);
    rq.size = 16'(z);
    rq.local_sends = ls;
    rq.first = fr;
    return rq;
  endfunction

  function automatic request_t rand_req();
    request_t rq;
    int m;
    m = ($urandom_range(9) < 3) ? $urandom_range(100) : $urandom_range(65535);
    rq.bye = ($urandom_range(9) < 3);
    rq.members = 16'(m);
    rq.senders = 16'(($urandom_range(1) == 1) ? $urandom_range(m / 3 + 1)
                                              : $urandom_range(65535));
    rq.leaving = 16'(($urandom_range(1) == 1) ? $urandom_range(200)
                                              : $urandom_range(65535));
    rq.size = 16'(($urandom_range(3) == 0) ? $urandom_range(300)
                                           : $urandom_range(65535));
    rq.local_sends = 1'($urandom_range(1));
    rq.first = 1'($urandom_range(1));
    return rq;
  endfunction

  task automatic directed_set();
    send_request(make_req(0, 10, 2, 0, 100, 1, 0));
    send_request(make_req(0, 10, 2, 0, 100, 0, 1));
    send_request(make_req(0, 10, 9, 0, 100, 0, 0));
    send_request(make_req(0, 3, 9, 0, 100, 1, 1));
    send_request(make_req(0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(0, 0, 0, 0, 65535, 1, 0));
    send_request(make_req(0, 65535, 65535, 65535, 65535, 1, 1));
    send_request(make_req(0, 65535, 0, 0, 65535, 0, 0));
    send_request(make_req(0, 65535, 16383, 0, 65535, 1, 0));
    send_request(make_req(0, 65535, 16384, 0, 65535, 0, 0));
    send_request(make_req(1, 49, 0, 65535, 65535, 0, 0));
    send_request(make_req(1, 50, 0, 65535, 65535, 1, 1));
    send_request(make_req(1, 65535, 3, 0, 100, 0, 0));
    send_request(make_req(1, 200, 0, 120, 0, 0, 0));
    send_request(make_req(1, 0, 65535, 65535, 65535, 1, 1));
    send_request(make_req(0, 40, 10, 0, 20, 1, 0));
    send_request(make_req(0, 40, 11, 0, 20, 0, 1));
  endtask

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 3 && i < count / 3 + 40);
      send_request(rand_req());
    end
    no_idle = 0;
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off on request.
  initial begin
    int cyc;
    out_ready = 1'b0;
    cyc = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (299) @(posedge clk);
        hold_req = 0;
      end
      out_ready <= (cyc % 4000 < 600) || ($urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_interval_ns, out_no_rtcp);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    quiet_cycles = 0;
    hold_req = 0;
    no_idle = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = 1'b0;
    in_member_count = '0;
    in_sender_count = '0;
    in_leaving_count = '0;
    in_avg_packet_bytes = '0;
    in_local_sends = 1'b0;
    in_first_report = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_RTCP_BPS;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: zero bandwidth, so requests report no RTCP except
    // small BYE sessions.
    directed_set();
    drain();

    write_reg(REG_RTCP_BPS, 32'd1000);
    write_reg(REG_MIN_INTERVAL, 32'd0);
    directed_set();
    drain();

    write_reg(REG_RTCP_BPS, 32'hFFFF_FFFF);
    write_reg(REG_SENDER_SHARE, 32'd0);
    directed_set();
    hold_req = 1;
    random_run(80);
    drain();

    write_reg(REG_RTCP_BPS, 32'd1);
    write_reg(REG_SENDER_SHARE, 32'd65536);
    write_reg(REG_MIN_INTERVAL, 32'hFFFF_FFFF);
    random_run(60);
    drain();

    write_reg(REG_SENDER_SHARE, 32'hFFFF_FFFF);
    write_reg(REG_MIN_INTERVAL, 32'd1);
    random_run(60);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_reg(REG_RTCP_BPS, ($urandom_range(1) == 1) ? $urandom_range(5000) : $urandom());
      write_reg(REG_SENDER_SHARE, $urandom_range(70000));
      write_reg(REG_MIN_INTERVAL, ($urandom_range(1) == 1) ? $urandom_range(1000) : $urandom());
      random_run(60);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (sb.pending.size() != 0 && sb.mismatches < 10)
        $display("ERROR: %0d results never arrived", sb.pending.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/rri_pkg.sv
hw/rtl/rri_prep.sv
hw/rtl/rri_div_step.sv
hw/rtl/rtcp_report_interval.sv
hw/rtl/rri_checker.sv
tb/sv/tb_top.sv
